// File: sv/prl_pkg.sv
// Package with shared types, constants and codes for the peer rate limiter.
package prl_pkg;

  typedef struct packed {
    logic        op;
    logic [63:0] peer_key;
    logic [63:0] now_time;
    logic [16:0] answer_uncertainty;
    logic        served_here;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  decision;
    logic [3:0]  slot_index;
    logic        newly_added;
    logic [16:0] minute_count;
    logic [20:0] hour_count;
    logic [16:0] peer_reputation;
    logic [16:0] minute_limit;
    logic [31:0] sent_count;
    logic [31:0] served_count;
  } rsp_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [1:0] DEC_ALLOW = 2'd0;
  localparam logic [1:0] DEC_RATE  = 2'd1;
  localparam logic [1:0] DEC_GIVE  = 2'd2;
  localparam logic [1:0] DEC_BLOCK = 2'd3;

  localparam logic [2:0] REG_MINUTE = 3'd0;
  localparam logic [2:0] REG_HOUR   = 3'd1;
  localparam logic [2:0] REG_BAN    = 3'd2;
  localparam logic [2:0] REG_TRUST  = 3'd3;
  localparam logic [2:0] REG_GIVE   = 3'd4;
  localparam logic [2:0] REG_REJECT = 3'd5;
  localparam logic [2:0] REG_GRACE  = 3'd6;

  localparam logic [63:0] MINUTE_NS     = 64'd60000000000;
  localparam logic [63:0] HOUR_NS       = 64'd3600000000000;
  localparam logic [63:0] DEFAULT_GRACE = 64'd600000000000;
  localparam logic [16:0] REP_ONE       = 17'd65536;
  localparam logic [16:0] REP_START     = 17'd32768;
  localparam logic [16:0] RATE_PENALTY  = 17'd9830;
  localparam logic [16:0] ANSWER_LOSS   = 17'd6554;
  localparam logic [16:0] ANSWER_GAIN   = 17'd3277;
  localparam logic [31:0] GIVE_MIN_SENT = 32'd10;
  localparam logic [31:0] SAT32         = 32'hFFFFFFFF;

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH, S_SRCH_W, S_VICT, S_VICT_W, S_LOAD, S_LOAD_W,
    S_CALC, S_GIVE, S_DEC, S_WRITE, S_DONE
  } state_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic take_req;
    logic rd_issue;
    logic srch_check;
    logic scan_clr;
    logic vict_check;
    logic alloc;
    logic load;
    logic calc;
    logic give;
    logic decide;
    logic write;
    logic emit_fail;
    logic emit;
  } cmd_t;

  // Datapath status to the controller.
  typedef struct packed {
    logic empty_key;
    logic hit;
    logic scan_last;
    logic table_full;
    logic have_victim;
    logic is_observe;
  } sts_t;

endpackage

// File: sv/prl_ram.sv
// Generic single-port RAM with registered read.
module prl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: sv/prl_ctrl.sv
// Controller state machine for the peer rate limiter.
module prl_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  prl_pkg::sts_t sts,
  output prl_pkg::cmd_t cmd,
  output logic          busy
);

  prl_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    case (state)
      prl_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.take_req = 1'b1;
          state_next = prl_pkg::S_SRCH;
        end
      end
      prl_pkg::S_SRCH: begin
        if (sts.empty_key) begin
          cmd.emit_fail = 1'b1;
          state_next = prl_pkg::S_IDLE;
        end else if (sts.scan_last) begin
          if (sts.table_full) begin
            // The eviction scan walks the table again from entry zero.
            cmd.scan_clr = 1'b1;
            state_next = prl_pkg::S_VICT;
          end else begin
            cmd.alloc = 1'b1;
            state_next = prl_pkg::S_LOAD;
          end
        end else begin
          cmd.rd_issue = 1'b1;
          state_next = prl_pkg::S_SRCH_W;
        end
      end
      prl_pkg::S_SRCH_W: begin
        cmd.srch_check = 1'b1;
        if (sts.hit) begin
          state_next = prl_pkg::S_LOAD;
        end else begin
          state_next = prl_pkg::S_SRCH;
        end
      end
      prl_pkg::S_VICT: begin
        if (sts.scan_last) begin
          if (sts.have_victim) begin
            cmd.alloc = 1'b1;
            state_next = prl_pkg::S_LOAD;
          end else begin
            cmd.emit_fail = 1'b1;
            state_next = prl_pkg::S_IDLE;
          end
        end else begin
          cmd.rd_issue = 1'b1;
          state_next = prl_pkg::S_VICT_W;
        end
      end
      prl_pkg::S_VICT_W: begin
        cmd.vict_check = 1'b1;
        state_next = prl_pkg::S_VICT;
      end
      prl_pkg::S_LOAD: begin
        state_next = prl_pkg::S_LOAD_W;
      end
      prl_pkg::S_LOAD_W: begin
        cmd.load = 1'b1;
        state_next = prl_pkg::S_CALC;
      end
      prl_pkg::S_CALC: begin
        cmd.calc = 1'b1;
        if (sts.is_observe) begin
          state_next = prl_pkg::S_WRITE;
        end else begin
          state_next = prl_pkg::S_GIVE;
        end
      end
      prl_pkg::S_GIVE: begin
        cmd.give = 1'b1;
        state_next = prl_pkg::S_DEC;
      end
      prl_pkg::S_DEC: begin
        cmd.decide = 1'b1;
        state_next = prl_pkg::S_WRITE;
      end
      prl_pkg::S_WRITE: begin
        cmd.write = 1'b1;
        state_next = prl_pkg::S_DONE;
      end
      prl_pkg::S_DONE: begin
        cmd.emit = 1'b1;
        state_next = prl_pkg::S_IDLE;
      end
      default: begin
        state_next = prl_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: sv/prl_dpath.sv
// Datapath of the peer rate limiter: entry memory, scan, update and result.
module prl_dpath #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  prl_pkg::cmd_t cmd,
  output prl_pkg::sts_t sts,
  input  prl_pkg::req_t req_in,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [63:0]   cfg_data,
  output logic          result_valid,
  output prl_pkg::rsp_t result_word
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  // Entry layout in one memory word.
  typedef struct packed {
    logic [63:0] key;
    logic [63:0] last_seen;
    logic [16:0] rep;
    logic        banned;
    logic [63:0] min_start;
    logic [63:0] hour_start;
    logic [16:0] min_cnt;
    logic [20:0] hour_cnt;
    logic [31:0] sent;
    logic [31:0] served;
  } entry_t;

  localparam int EW = $bits(entry_t);

  // Configuration registers.
  logic [15:0] minute_quota;
  logic [19:0] hour_quota;
  logic [16:0] ban_threshold, trust_threshold, give_ratio_min, answer_reject_level;
  logic [63:0] evict_grace_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      minute_quota        <= 16'd5;
      hour_quota          <= 20'd60;
      ban_threshold       <= 17'd6554;
      trust_threshold     <= 17'd52429;
      give_ratio_min      <= 17'd6554;
      answer_reject_level <= 17'd45875;
      evict_grace_time    <= 64'd600000000000;
    end else if (cfg_we) begin
      case (cfg_index)
        prl_pkg::REG_MINUTE: minute_quota        <= cfg_data[15:0];
        prl_pkg::REG_HOUR:   hour_quota          <= cfg_data[19:0];
        prl_pkg::REG_BAN:    ban_threshold       <= cfg_data[16:0];
        prl_pkg::REG_TRUST:  trust_threshold     <= cfg_data[16:0];
        prl_pkg::REG_GIVE:   give_ratio_min      <= cfg_data[16:0];
        prl_pkg::REG_REJECT: answer_reject_level <= cfg_data[16:0];
        prl_pkg::REG_GRACE:  evict_grace_time    <= cfg_data;
        default: ;
      endcase
    end
  end

  prl_pkg::req_t req;
  logic [16:0]   unc;
  logic [CW-1:0] entries_used;
  logic [CW-1:0] scan;
  logic [AW-1:0] slot;
  logic          fresh;
  logic          have_victim;
  logic [AW-1:0] victim;
  logic [16:0]   worst;
  entry_t        ent;
  logic [1:0]    decision;
  logic          trusted;
  logic [63:0]   lhs;
  logic [63:0]   rhs;

  // Memory port.
  logic [AW-1:0] ram_addr;
  logic          ram_we;
  entry_t        ram_wdata;
  entry_t        ram_rdata;

  prl_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    ram_we    = cmd.write;
    ram_wdata = ent;
    if (cmd.rd_issue) begin
      ram_addr = scan[AW-1:0];
    end else begin
      ram_addr = slot;
    end
  end

  logic [63:0] grace;
  logic [63:0] idle;
  assign grace = (evict_grace_time == 64'd0) ? prl_pkg::DEFAULT_GRACE : evict_grace_time;
  assign idle  = req.now_time - ram_rdata.last_seen;

  assign sts.empty_key   = (req.op == 1'b0) && (req.peer_key == 64'd0);
  assign sts.hit         = (ram_rdata.key == req.peer_key);
  assign sts.scan_last   = (scan >= entries_used);
  assign sts.table_full  = (entries_used == DEPTH_C);
  assign sts.have_victim = have_victim;
  assign sts.is_observe  = req.op;

  logic [16:0] lim_min;
  logic [20:0] lim_hour;
  assign trusted  = (ent.rep >= trust_threshold);
  assign lim_min  = trusted ? {minute_quota, 1'b0} : {1'b0, minute_quota};
  assign lim_hour = trusted ? {hour_quota, 1'b0} : {1'b0, hour_quota};

  logic [33:0] gain_prod;
  logic [16:0] gain;
  logic [17:0] rep_sum;
  assign gain_prod = 34'(prl_pkg::ANSWER_GAIN) * 34'(prl_pkg::REP_ONE - unc) + 34'd32768;
  assign gain      = gain_prod[32:16];
  assign rep_sum   = {1'b0, ent.rep} + {1'b0, gain};

  // Entry as loaded: a fresh allocation or the stored entry, stamped with the request time.
  entry_t load_ent;
  always_comb begin
    if (fresh) begin
      load_ent          = '0;
      load_ent.key      = req.peer_key;
      load_ent.rep      = prl_pkg::REP_START;
      load_ent.min_start  = req.now_time;
      load_ent.hour_start = req.now_time;
    end else begin
      load_ent = ram_rdata;
    end
    load_ent.last_seen = req.now_time;
  end

  // Result word for an empty key or a full table without a victim.
  prl_pkg::rsp_t fail_word;
  always_comb begin
    fail_word        = '0;
    fail_word.status = sts.empty_key ? prl_pkg::ST_EMPTY : prl_pkg::ST_FULL;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_used <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit || cmd.emit_fail;
      if (cmd.alloc && !sts.table_full) begin
        entries_used <= entries_used + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_req) begin
      req   <= req_in;
      unc   <= (req_in.answer_uncertainty > prl_pkg::REP_ONE) ? prl_pkg::REP_ONE
                                                            : req_in.answer_uncertainty;
      scan  <= '0;
      fresh <= 1'b0;
      have_victim <= 1'b0;
      victim <= '0;
      worst  <= '0;
    end
    if (cmd.rd_issue) begin
      slot <= scan[AW-1:0];
    end
    if (cmd.srch_check) begin
      scan <= scan + 1'b1;
    end
    if (cmd.scan_clr) begin
      scan <= '0;
    end
    if (cmd.vict_check) begin
      scan <= scan + 1'b1;
      if ((ram_rdata.rep < trust_threshold) && (idle >= grace) &&
          (!have_victim || ram_rdata.rep < worst)) begin
        have_victim <= 1'b1;
        victim      <= slot;
        worst       <= ram_rdata.rep;
      end
    end
    if (cmd.alloc) begin
      fresh <= 1'b1;
      if (sts.table_full) begin
        slot <= victim;
      end else begin
        slot <= entries_used[AW-1:0];
      end
    end
    if (cmd.load) begin
      ent <= load_ent;
    end
    if (cmd.calc) begin
      if (req.op) begin
        if (req.served_here) begin
          if (ent.served != prl_pkg::SAT32) ent.served <= ent.served + 32'd1;
        end else if (unc >= answer_reject_level) begin
          ent.rep <= (ent.rep > prl_pkg::ANSWER_LOSS) ? ent.rep - prl_pkg::ANSWER_LOSS : '0;
        end else begin
          ent.rep <= (rep_sum > {1'b0, prl_pkg::REP_ONE}) ? prl_pkg::REP_ONE : rep_sum[16:0];
        end
        decision <= prl_pkg::DEC_ALLOW;
      end else begin
        if (req.now_time - ent.min_start >= prl_pkg::MINUTE_NS) begin
          ent.min_start <= req.now_time;
          ent.min_cnt   <= '0;
        end
        if (req.now_time - ent.hour_start >= prl_pkg::HOUR_NS) begin
          ent.hour_start <= req.now_time;
          ent.hour_cnt   <= '0;
        end
      end
    end
    if (cmd.give) begin
      lhs <= {ent.served, 32'd0} >> 16;
      rhs <= 64'(give_ratio_min) * 64'(ent.sent);
    end
    if (cmd.decide) begin
      if (ent.banned || ent.rep < ban_threshold) begin
        ent.banned <= 1'b1;
        decision   <= prl_pkg::DEC_BLOCK;
      end else if (ent.min_cnt >= lim_min || ent.hour_cnt >= lim_hour) begin
        ent.rep  <= (ent.rep > prl_pkg::RATE_PENALTY) ? ent.rep - prl_pkg::RATE_PENALTY : '0;
        decision <= prl_pkg::DEC_RATE;
      end else if (ent.sent >= prl_pkg::GIVE_MIN_SENT && lhs < rhs) begin
        decision <= prl_pkg::DEC_GIVE;
      end else begin
        decision <= prl_pkg::DEC_ALLOW;
        if (ent.sent != prl_pkg::SAT32) ent.sent <= ent.sent + 32'd1;
        ent.min_cnt  <= ent.min_cnt + 17'd1;
        ent.hour_cnt <= ent.hour_cnt + 21'd1;
      end
    end
    if (cmd.emit_fail) begin
      result_word <= fail_word;
    end else if (cmd.emit) begin
      result_word.status          <= prl_pkg::ST_OK;
      result_word.decision        <= decision;
      result_word.slot_index      <= 4'(slot);
      result_word.newly_added     <= fresh;
      result_word.minute_count    <= ent.min_cnt;
      result_word.hour_count      <= ent.hour_cnt;
      result_word.peer_reputation <= ent.rep;
      result_word.minute_limit    <= lim_min;
      result_word.sent_count      <= ent.sent;
      result_word.served_count    <= ent.served;
    end
  end

endmodule

// File: sv/peer_rate_limiter_with_reputation_top.sv
// Top level of the peer rate limiter with reputation.
//
// Channel   Direction  Handshake                    Word
// request   in         start high while busy low    req (prl_pkg::req_t)
// result    out        done strobe, one cycle       rsp (prl_pkg::rsp_t)
// config    in         cfg_we, cfg_index, cfg_data  one register per write
//
// After a word is taken, busy stays high while the key search reads the used
// table entries. A check then runs load, update, write-back and output; an
// answer observation runs the same steps without the give-ratio and decision
// steps. A miss on a full table adds an eviction scan over every entry. An
// empty key on a check ends the search with a fail word. The single-port entry
// memory makes both scans read one entry at a time. The result shows on done
// in the first cycle after busy falls, which is also the first cycle a new word
// may be taken.
// Reset is synchronous and clears the fill count and configuration; entry
// memory contents are only read below the fill count. Results are shown for
// one cycle on done and cannot be held off by the receiver.
module peer_rate_limiter_with_reputation_top #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  prl_pkg::req_t req,
  output logic          done,
  output prl_pkg::rsp_t rsp,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [63:0]   cfg_data
);

  prl_pkg::cmd_t cmd;
  prl_pkg::sts_t sts;

  // The sequencer walks the search, eviction and update steps.
  prl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // The datapath holds the table, the registers and the result word.
  prl_dpath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .req_in       (req),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (done),
    .result_word  (rsp)
  );

endmodule

// File: bench/prl_checker.sv
// Checker for the peer rate limiter: predicts each result word and compares it.
module prl_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  input  prl_pkg::req_t req,
  input  logic          done,
  input  prl_pkg::rsp_t rsp,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [63:0]   cfg_data,
  output int            fail_count,
  output int            pending
);

  localparam int DEPTH = 16;

  logic [15:0] q_minute;
  logic [19:0] q_hour;
  logic [16:0] t_ban, t_trust, t_give, t_reject;
  logic [63:0] grace_ns;

  int          used;
  logic [63:0] p_key [DEPTH];
  logic [63:0] p_seen [DEPTH];
  logic [16:0] p_rep [DEPTH];
  logic        p_ban [DEPTH];
  logic [63:0] p_mstart [DEPTH];
  logic [63:0] p_hstart [DEPTH];
  logic [16:0] p_mcnt [DEPTH];
  logic [20:0] p_hcnt [DEPTH];
  logic [31:0] p_sent [DEPTH];
  logic [31:0] p_served [DEPTH];

  prl_pkg::rsp_t expected_q [$];

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic logic [16:0] limit_minute(int s);
    return (p_rep[s] >= t_trust) ? {q_minute, 1'b0} : {1'b0, q_minute};
  endfunction

  function automatic logic [20:0] limit_hour(int s);
    return (p_rep[s] >= t_trust) ? {q_hour, 1'b0} : {1'b0, q_hour};
  endfunction

  function automatic prl_pkg::rsp_t admit(input prl_pkg::req_t r);
    prl_pkg::rsp_t o;
    int s, victim;
    logic fresh;
    logic [1:0] dec;
    logic [16:0] unc, worst;
    logic [63:0] gr;
    logic [31:0] gain;
    logic [63:0] lhs, rhs;
    o = '0;
    s = -1;
    fresh = 0;
    dec = prl_pkg::DEC_ALLOW;
    unc = (r.answer_uncertainty > prl_pkg::REP_ONE) ? prl_pkg::REP_ONE : r.answer_uncertainty;
    if (!r.op && r.peer_key == 0) begin
      o.status = prl_pkg::ST_EMPTY;
      return o;
    end
    for (int i = 0; i < used; i++)
      if (s < 0 && p_key[i] == r.peer_key) s = i;
    if (s < 0) begin
      if (used < DEPTH) begin
        s = used;
        used++;
      end else begin
        // Evict the lowest-reputation untrusted peer idle past the grace time.
        gr = grace_ns ? grace_ns : prl_pkg::DEFAULT_GRACE;
        victim = -1;
        worst = 0;
        for (int i = 0; i < DEPTH; i++) begin
          if (p_rep[i] >= t_trust) continue;
          if (r.now_time - p_seen[i] < gr) continue;
          if (victim < 0 || p_rep[i] < worst) begin
            worst = p_rep[i];
            victim = i;
          end
        end
        if (victim < 0) begin
          o.status = prl_pkg::ST_FULL;
          return o;
        end
        s = victim;
      end
      p_key[s] = r.peer_key;
      p_rep[s] = prl_pkg::REP_START;
      p_ban[s] = 0;
      p_mstart[s] = r.now_time;
      p_hstart[s] = r.now_time;
      p_mcnt[s] = 0;
      p_hcnt[s] = 0;
      p_sent[s] = 0;
      p_served[s] = 0;
      fresh = 1;
    end
    p_seen[s] = r.now_time;
    if (r.op) begin
      if (r.served_here) begin
        if (p_served[s] != prl_pkg::SAT32) p_served[s]++;
      end else if (unc >= t_reject) begin
        p_rep[s] = (p_rep[s] > prl_pkg::ANSWER_LOSS) ? p_rep[s] - prl_pkg::ANSWER_LOSS : '0;
      end else begin
        gain = (32'(prl_pkg::ANSWER_GAIN) * (32'(prl_pkg::REP_ONE) - 32'(unc)) + 32'd32768)
               >> 16;
        gain = gain + 32'(p_rep[s]);
        p_rep[s] = (gain > 32'(prl_pkg::REP_ONE)) ? prl_pkg::REP_ONE : gain[16:0];
      end
    end else begin
      if (r.now_time - p_mstart[s] >= prl_pkg::MINUTE_NS) begin
        p_mstart[s] = r.now_time;
        p_mcnt[s] = 0;
      end
      if (r.now_time - p_hstart[s] >= prl_pkg::HOUR_NS) begin
        p_hstart[s] = r.now_time;
        p_hcnt[s] = 0;
      end
      if (p_ban[s] || p_rep[s] < t_ban) begin
        p_ban[s] = 1;
        dec = prl_pkg::DEC_BLOCK;
      end else if (p_mcnt[s] >= limit_minute(s) || p_hcnt[s] >= limit_hour(s)) begin
        p_rep[s] = (p_rep[s] > prl_pkg::RATE_PENALTY) ? p_rep[s] - prl_pkg::RATE_PENALTY : '0;
        dec = prl_pkg::DEC_RATE;
      end else if (p_sent[s] >= prl_pkg::GIVE_MIN_SENT) begin
        lhs = 64'(p_served[s]) * 64'(prl_pkg::REP_ONE);
        rhs = 64'(t_give) * 64'(p_sent[s]);
        if (lhs < rhs) dec = prl_pkg::DEC_GIVE;
      end
      if (dec == prl_pkg::DEC_ALLOW) begin
        if (p_sent[s] != prl_pkg::SAT32) p_sent[s]++;
        p_mcnt[s]++;
        p_hcnt[s]++;
      end
    end
    o.status = prl_pkg::ST_OK;
    o.decision = dec;
    o.slot_index = s[3:0];
    o.newly_added = fresh;
    o.minute_count = p_mcnt[s];
    o.hour_count = p_hcnt[s];
    o.peer_reputation = p_rep[s];
    o.minute_limit = limit_minute(s);
    o.sent_count = p_sent[s];
    o.served_count = p_served[s];
    return o;
  endfunction

  initial fail_count = 0;

  always @(posedge clk) begin
    prl_pkg::rsp_t want;
    if (rst) begin
      q_minute = 16'd5;
      q_hour = 20'd60;
      t_ban = 17'd6554;
      t_trust = 17'd52429;
      t_give = 17'd6554;
      t_reject = 17'd45875;
      grace_ns = prl_pkg::DEFAULT_GRACE;
      used = 0;
    end else begin
      // A result is compared before a new word is taken in the same edge.
      if (done) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected word", 64'(rsp.status), 64'd0);
        end else begin
          want = expected_q.pop_front();
          if (rsp.status != want.status)
            report_mismatch("status", 64'(rsp.status), 64'(want.status));
          if (rsp.decision != want.decision)
            report_mismatch("decision", 64'(rsp.decision), 64'(want.decision));
          if (rsp.slot_index != want.slot_index)
            report_mismatch("slot_index", 64'(rsp.slot_index), 64'(want.slot_index));
          if (rsp.newly_added != want.newly_added)
            report_mismatch("newly_added", 64'(rsp.newly_added), 64'(want.newly_added));
          if (rsp.minute_count != want.minute_count)
            report_mismatch("minute_count", 64'(rsp.minute_count), 64'(want.minute_count));
          if (rsp.hour_count != want.hour_count)
            report_mismatch("hour_count", 64'(rsp.hour_count), 64'(want.hour_count));
          if (rsp.peer_reputation != want.peer_reputation)
            report_mismatch("peer_reputation", 64'(rsp.peer_reputation),
                            64'(want.peer_reputation));
          if (rsp.minute_limit != want.minute_limit)
            report_mismatch("minute_limit", 64'(rsp.minute_limit), 64'(want.minute_limit));
          if (rsp.sent_count != want.sent_count)
            report_mismatch("sent_count", 64'(rsp.sent_count), 64'(want.sent_count));
          if (rsp.served_count != want.served_count)
            report_mismatch("served_count", 64'(rsp.served_count), 64'(want.served_count));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          prl_pkg::REG_MINUTE: q_minute = cfg_data[15:0];
          prl_pkg::REG_HOUR:   q_hour = cfg_data[19:0];
          prl_pkg::REG_BAN:    t_ban = cfg_data[16:0];
          prl_pkg::REG_TRUST:  t_trust = cfg_data[16:0];
          prl_pkg::REG_GIVE:   t_give = cfg_data[16:0];
          prl_pkg::REG_REJECT: t_reject = cfg_data[16:0];
          prl_pkg::REG_GRACE:  grace_ns = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) expected_q.push_back(admit(req));
    end
    pending = expected_q.size();
  end
endmodule

// File: bench/tb.sv
// Testbench top: drives words and register writes into the rate limiter and gives the verdict.
module tb;

  logic          clk;
  logic          rst;
  logic          start;
  logic          busy;
  prl_pkg::req_t req;
  logic          done;
  prl_pkg::rsp_t rsp;
  logic          cfg_we;
  logic [2:0]    cfg_index;
  logic [63:0]   cfg_data;
  int            fail_count;
  int            pending;

  // Time base for requests; the stimulus moves it forward in small or large steps.
  logic [63:0]   clock_ns;
  logic [63:0]   pool [8];
  int            sent_words;

  peer_rate_limiter_with_reputation_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  prl_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // The limit allows the 400-odd words with their gaps and drains, many times over.
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  // Hands one word to the block. The word is raised at a falling edge and held
  // until an edge that sees busy low takes it; start drops only before an idle gap or when no word follows.
  task automatic send_word(input prl_pkg::req_t w, input bit idle_ok);
    int gap;
    if (idle_ok && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      @(negedge clk);
      start <= 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req <= w;
    start <= 1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sent_words++;
    // start stays high; an idle gap in the next call or a drain lowers it at the next falling edge.
  endtask

  task automatic drop_start();
    @(negedge clk);
    start <= 0;
  endtask

  // Waits until every expected word has come, then lets the block settle.
  task automatic drain();
    drop_start();
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  function automatic prl_pkg::req_t make_word(input logic op, input logic [63:0] key,
                                              input logic [63:0] t_ns,
                                              input logic [16:0] unc, input logic srv);
    prl_pkg::req_t w;
    w.op = op;
    w.peer_key = key;
    w.now_time = t_ns;
    w.answer_uncertainty = unc;
    w.served_here = srv;
    return w;
  endfunction

  // One random word: mostly checks and answers from a small pool of peers,
  // with time stepping so that windows roll and idle peers become evictable.
  task automatic random_word(input bit idle_ok);
    logic [63:0] key;
    logic [16:0] unc;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) clock_ns = clock_ns + 64'd700000000000;
    else if (pick < 10) clock_ns = clock_ns + 64'd61000000000;
    else clock_ns = clock_ns + 64'($urandom_range(0, 3000000000));
    if ($urandom_range(0, 19) == 0) key = {$urandom, $urandom};
    else if ($urandom_range(0, 49) == 0) key = 64'd0;
    else key = pool[$urandom_range(0, 7)] + 64'($urandom_range(0, 2) * 16);
    unc = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
    send_word(make_word($urandom_range(0, 2) == 0, key, clock_ns, unc,
                        1'($urandom_range(0, 1))), idle_ok);
  endtask

  initial begin
    start = 0;
    req = '0;
    cfg_we = 0;
    cfg_index = prl_pkg::REG_MINUTE;
    cfg_data = '0;
    sent_words = 0;
    clock_ns = 64'd1000;
    for (int i = 0; i < 8; i++) pool[i] = {$urandom, $urandom} | 64'd1;
    rst = 1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed part: empty key, extreme keys and times, saturated uncertainty,
    // answers of both kinds, a ban, rate throttling and a full table.
    send_word(make_word(0, 64'd0, 64'd5, 17'd0, 0), 0);
    send_word(make_word(1, 64'd0, 64'd5, 17'h1FFFF, 0), 0);
    send_word(make_word(0, '1, '1, 17'd0, 1), 0);
    send_word(make_word(1, '1, 64'd0, 17'd65536, 1), 0);
    for (int i = 0; i < 7; i++)
      send_word(make_word(0, 64'd77, 64'd100 + 64'(i), 17'd0, 0), 0);
    for (int i = 0; i < 5; i++)
      send_word(make_word(1, 64'd88, 64'd200, 17'd65536, 0), 0);
    send_word(make_word(0, 64'd88, 64'd300, 17'd0, 0), 0);
    send_word(make_word(1, 64'd77, 64'd400, 17'd0, 0), 0);
    for (int i = 0; i < 14; i++)
      send_word(make_word(0, 64'd1000 + 64'(i), 64'd500, 17'd0, 0), 0);
    send_word(make_word(0, 64'd5000, 64'd600, 17'd0, 0), 0);
    send_word(make_word(0, 64'd5001, 64'd900000000000, 17'd0, 0), 0);
    drain();

    // Extreme settings: tight quotas, zero grace, thresholds at their ends.
    write_reg(prl_pkg::REG_MINUTE, 64'd1);
    write_reg(prl_pkg::REG_HOUR, 64'd1);
    write_reg(prl_pkg::REG_BAN, 64'd0);
    write_reg(prl_pkg::REG_TRUST, 64'd65536);
    write_reg(prl_pkg::REG_GIVE, 64'd65536);
    write_reg(prl_pkg::REG_REJECT, 64'd0);
    write_reg(prl_pkg::REG_GRACE, 64'd0);
    clock_ns = 64'd2000000000000;
    for (int i = 0; i < 100; i++) random_word(1);
    drain();

    // Wide quotas and the opposite threshold ends.
    write_reg(prl_pkg::REG_MINUTE, 64'd65535);
    write_reg(prl_pkg::REG_HOUR, 64'd1048575);
    write_reg(prl_pkg::REG_BAN, 64'd65536);
    write_reg(prl_pkg::REG_TRUST, 64'd0);
    write_reg(prl_pkg::REG_GIVE, 64'd0);
    write_reg(prl_pkg::REG_REJECT, 64'd65536);
    write_reg(prl_pkg::REG_GRACE, '1);
    for (int i = 0; i < 60; i++) random_word(1);
    drain();

    // Mid settings where all four decisions show up.
    write_reg(prl_pkg::REG_MINUTE, 64'd4);
    write_reg(prl_pkg::REG_HOUR, 64'd20);
    write_reg(prl_pkg::REG_BAN, 64'd20000);
    write_reg(prl_pkg::REG_TRUST, 64'd45000);
    write_reg(prl_pkg::REG_GIVE, 64'd13000);
    write_reg(prl_pkg::REG_REJECT, 64'd30000);
    write_reg(prl_pkg::REG_GRACE, 64'd30000000000);
    for (int i = 0; i < 180; i++) random_word(1);

    // Last stretch without idling.
    for (int i = 0; i < 60; i++) random_word(0);
    drain();

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
